/* rtl/rrtq_pkg.sv */
// rrtq_pkg: shared codes and types for the round robin thread queue
// used by rrtq_cell and round_robin_thread_queue_unit; depends on nothing
package rrtq_pkg;

  localparam int MODE_W   = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 5;

  // item modes
  localparam logic [MODE_W-1:0] MODE_ADMIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

  // what a cell does while the sweep token sits on it
  typedef enum logic [1:0] {
    OP_FIND,
    OP_REMOVE,
    OP_ROTATE
  } sweep_op_t;

  // per-cell control from the sequencer
  typedef struct packed {
    sweep_op_t op;
    logic      occupied;
    logic      is_last;
    logic      append;
  } cell_ctl_t;

endpackage

/* rtl/round_robin_thread_queue_unit.sv */
// round_robin_thread_queue_unit: top level, sequencer plus a row of rrtq_cell slots
// depends on rrtq_pkg and rrtq_cell

// An ordered queue of up to MAX_THREADS thread identifiers, head in cell 0.
// Each input word carries a mode (admit, remove, serve next, clear) and an
// identifier; each gives exactly one result word with status, served
// identifier and queue length. Admit, remove and serve next walk a token
// down the chain of cells, one cell per cycle: every cell compares its slot
// with the key and passes a running "found" flag on, and on remove or
// rotate a cell copies its right neighbour as the token passes, so the gap
// closes or the head moves to the tail without any wide mux. An item that
// sweeps gets its result word once the token has walked over all cells;
// clear and refused items (full, empty) skip the sweep and go straight to
// the result. One item is worked on at a time, but a finished result may
// wait in the output register while the next word is taken in.
// Identifiers are compared in their low ID_BITS bits.
module round_robin_thread_queue_unit #(
  parameter int MAX_THREADS = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrtq_pkg::MODE_W-1:0]   mode,
  input  logic [rrtq_pkg::TID_W-1:0]    thread_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrtq_pkg::STATUS_W-1:0] status,
  output logic [rrtq_pkg::TID_W-1:0]    served_id,
  output logic [rrtq_pkg::LEN_W-1:0]    fill_level
);

  localparam int OCC_W = $clog2(MAX_THREADS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                        state;
  logic                          start;
  rrtq_pkg::sweep_op_t           sweep_op;
  logic [rrtq_pkg::MODE_W-1:0]   mode_q;
  logic [ID_BITS-1:0]            key_q;
  logic [ID_BITS-1:0]            head_q;
  logic [rrtq_pkg::STATUS_W-1:0] res_status;
  logic [OCC_W-1:0]              occ;
  logic [OCC_W-1:0]              occ_next;

  logic [ID_BITS-1:0]            key_in;
  logic                          emit;
  logic                          append_now;
  logic                          queue_full;
  logic                          queue_empty;

  // chain wiring, one extra tap at each end
  logic [ID_BITS-1:0]            slots [MAX_THREADS];
  logic [MAX_THREADS:0]          tok_chain;
  logic [MAX_THREADS:0]          hit_chain;

  assign key_in      = ID_BITS'(thread_id);
  assign in_ready    = (state == S_IDLE);
  assign queue_full  = (occ == OCC_W'(MAX_THREADS));
  assign queue_empty = (occ == '0);

  // result register free: either empty or being drained this cycle
  assign emit       = (state == S_DONE) && (!out_valid || out_ready);
  assign append_now = emit && (mode_q == rrtq_pkg::MODE_ADMIT) &&
                      (res_status == rrtq_pkg::ST_OK);

  always_comb begin
    occ_next = occ;
    if (mode_q == rrtq_pkg::MODE_CLEAR) begin
      occ_next = '0;
    end else if (res_status == rrtq_pkg::ST_OK) begin
      if (mode_q == rrtq_pkg::MODE_ADMIT) begin
        occ_next = occ + OCC_W'(1);
      end else if (mode_q == rrtq_pkg::MODE_REMOVE) begin
        occ_next = occ - OCC_W'(1);
      end
    end
  end

  // token enters at the head, running found flag starts clear
  assign tok_chain[0] = start;
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    rrtq_pkg::cell_ctl_t ctl;
    logic [ID_BITS-1:0]  right;

    assign ctl.op       = sweep_op;
    assign ctl.occupied = (occ > OCC_W'(i));
    assign ctl.is_last  = (occ == OCC_W'(i + 1));
    // append lands on the first free slot, compared with the old length
    assign ctl.append   = append_now && (occ == OCC_W'(i));

    if (i == MAX_THREADS - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = slots[i + 1];
    end

    rrtq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .key     (key_q),
      .head    (head_q),
      .right   (right),
      .tok_in  (tok_chain[i]),
      .hit_in  (hit_chain[i]),
      .slot    (slots[i]),
      .tok_out (tok_chain[i + 1]),
      .hit_out (hit_chain[i + 1])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= 1'b0;
      occ       <= '0;
      out_valid <= 1'b0;
      sweep_op  <= rrtq_pkg::OP_FIND;
    end else begin
      // a new result word replaces the one drained in the same cycle
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            key_q  <= key_in;
            head_q <= slots[0];
            unique case (mode)
              rrtq_pkg::MODE_ADMIT: begin
                if (queue_full) begin
                  res_status <= rrtq_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  sweep_op <= rrtq_pkg::OP_FIND;
                  start    <= 1'b1;
                  state    <= S_SWEEP;
                end
              end
              rrtq_pkg::MODE_REMOVE: begin
                if (queue_empty) begin
                  res_status <= rrtq_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  sweep_op <= rrtq_pkg::OP_REMOVE;
                  start    <= 1'b1;
                  state    <= S_SWEEP;
                end
              end
              rrtq_pkg::MODE_NEXT: begin
                if (queue_empty) begin
                  res_status <= rrtq_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  sweep_op <= rrtq_pkg::OP_ROTATE;
                  start    <= 1'b1;
                  state    <= S_SWEEP;
                end
              end
              default: begin
                res_status <= rrtq_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SWEEP: begin
          // token launched for one cycle only
          start <= 1'b0;
          // token on the last cell: the running flag now covers the whole queue
          if (tok_chain[MAX_THREADS]) begin
            state    <= S_DONE;
            sweep_op <= rrtq_pkg::OP_FIND;
            if (mode_q == rrtq_pkg::MODE_ADMIT) begin
              res_status <= hit_chain[MAX_THREADS] ? rrtq_pkg::ST_DUPLICATE
                                                   : rrtq_pkg::ST_OK;
            end else if (mode_q == rrtq_pkg::MODE_REMOVE) begin
              res_status <= hit_chain[MAX_THREADS] ? rrtq_pkg::ST_OK
                                                   : rrtq_pkg::ST_NOT_FOUND;
            end else begin
              res_status <= rrtq_pkg::ST_OK;
            end
          end
        end
        S_DONE: begin
          if (emit) begin
            status     <= res_status;
            served_id  <= ((mode_q == rrtq_pkg::MODE_NEXT) &&
                           (res_status == rrtq_pkg::ST_OK)) ?
                          rrtq_pkg::TID_W'(head_q) : '0;
            fill_level <= rrtq_pkg::LEN_W'(occ_next);
            occ        <= occ_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/rrtq_cell.sv */
// rrtq_cell: one queue slot of the chain, with its comparator and sweep token
// depends on rrtq_pkg
module rrtq_cell #(
  parameter int ID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  rrtq_pkg::cell_ctl_t ctl,
  input  logic [ID_BITS-1:0]  key,
  input  logic [ID_BITS-1:0]  head,
  input  logic [ID_BITS-1:0]  right,
  input  logic                tok_in,
  input  logic                hit_in,
  output logic [ID_BITS-1:0]  slot,
  output logic                tok_out,
  output logic                hit_out
);

  logic act;
  logic hit;
  logic here_hit;
  logic take_right;
  logic take_head;

  // hit so far includes every cell up to and including this one
  assign here_hit = hit | (ctl.occupied & (slot == key));
  assign hit_out  = here_hit;
  assign tok_out  = act;

  always_comb begin
    take_right = 1'b0;
    take_head  = 1'b0;
    case (ctl.op)
      rrtq_pkg::OP_REMOVE: begin
        take_right = act & ctl.occupied & here_hit & ~ctl.is_last;
      end
      rrtq_pkg::OP_ROTATE: begin
        take_right = act & ctl.occupied & ~ctl.is_last;
        take_head  = act & ctl.is_last;
      end
      default: begin
        take_right = 1'b0;
        take_head  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      hit <= 1'b0;
    end else begin
      act <= tok_in;
      hit <= hit_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      slot <= key;
    end else if (take_head) begin
      slot <= head;
    end else if (take_right) begin
      slot <= right;
    end
  end

endmodule
